>>> sv/trs_pkg.sv
// Shared types, codes and arithmetic helpers for the timed recipe sequencer.
// No dependencies; imported by timed_recipe_sequencer_core.
package trs_pkg;

   localparam int unsigned OpcodeWidth  = 3;
   localparam int unsigned AdcWidth     = 12;
   localparam int unsigned ModeWidth    = 2;
   localparam int unsigned ItemWidth    = 3;
   localparam int unsigned PhaseWidth   = 2;
   localparam int unsigned TimeWidth    = 6;
   localparam int unsigned DutyWidth    = 4;

   // q = floor(adc * QuantNum / QuantDen), duty = floor(adc / DutyDen)
   localparam int unsigned QuantNum     = 10;
   localparam int unsigned QuantDen     = 5851;
   localparam int unsigned QuantMax     = 6;
   localparam int unsigned QuantWidth   = 3;
   localparam int unsigned ProdWidth    = 16;
   localparam int unsigned DutyDen      = 410;
   localparam int unsigned DutyMax      = 9;
   localparam int unsigned StepTenths   = 5;

   typedef enum logic [OpcodeWidth-1:0] {
      OP_TICK   = 3'd0,
      OP_SAMPLE = 3'd1,
      OP_SAVE   = 3'd2,
      OP_TOGGLE = 3'd3,
      OP_START  = 3'd4,
      OP_NEXT   = 3'd5
   } opcode_type;

   typedef enum logic [3:0] {
      MODE_INPUT_IDLE = 4'b0001,
      MODE_RUN_IDLE   = 4'b0010,
      MODE_DETAIL     = 4'b0100,
      MODE_RUN        = 4'b1000
   } mode_type;

   typedef enum logic [3:0] {
      PHASE_IDLE  = 4'b0001,
      PHASE_TEMP  = 4'b0010,
      PHASE_PRESS = 4'b0100,
      PHASE_O2    = 4'b1000
   } phase_type;

   localparam logic [ItemWidth-1:0] ITEM_NONE  = 3'd0;
   localparam logic [ItemWidth-1:0] ITEM_TEMP  = 3'd1;
   localparam logic [ItemWidth-1:0] ITEM_PRESS = 3'd2;
   localparam logic [ItemWidth-1:0] ITEM_O2    = 3'd3;
   localparam logic [ItemWidth-1:0] ITEM_DUTY  = 3'd4;

   // threshold compare count: adc*10 >= 5851*k for k = 1..6
   function automatic logic [QuantWidth-1:0] quantize(input logic [AdcWidth-1:0] adc);
      logic [ProdWidth-1:0]  prod;
      logic [QuantWidth-1:0] q;
      prod = ProdWidth'(adc) * ProdWidth'(QuantNum);
      q    = '0;
      for (int k = 1; k <= QuantMax; k++) begin
         if (prod >= ProdWidth'(QuantDen * k)) q = q + 1'b1;
      end
      return q;
   endfunction

   function automatic logic [DutyWidth-1:0] duty_of(input logic [AdcWidth-1:0] adc);
      logic [DutyWidth-1:0] d;
      d = '0;
      for (int k = 1; k <= DutyMax; k++) begin
         if (adc >= AdcWidth'(DutyDen * k)) d = d + 1'b1;
      end
      return d;
   endfunction

   function automatic logic [TimeWidth-1:0] item_value(
      input logic [ItemWidth-1:0]  item,
      input logic [QuantWidth-1:0] q,
      input logic [DutyWidth-1:0]  duty
   );
      logic [TimeWidth-1:0] qx;
      logic [TimeWidth-1:0] v;
      qx = TimeWidth'(q);
      unique case (item)
         ITEM_TEMP:  v = TimeWidth'(StepTenths) * (qx + TimeWidth'(2));
         ITEM_PRESS: v = TimeWidth'(StepTenths) * (qx + TimeWidth'(1));
         ITEM_O2:    v = TimeWidth'(StepTenths) * qx;
         ITEM_DUTY:  v = TimeWidth'(duty);
         default:    v = '0;
      endcase
      return v;
   endfunction

   function automatic logic [ModeWidth-1:0] mode_code(input mode_type m);
      logic [ModeWidth-1:0] c;
      unique case (m)
         MODE_INPUT_IDLE: c = 2'd0;
         MODE_RUN_IDLE:   c = 2'd1;
         MODE_DETAIL:     c = 2'd2;
         MODE_RUN:        c = 2'd3;
         default:         c = 2'd0;
      endcase
      return c;
   endfunction

   function automatic logic [PhaseWidth-1:0] phase_code(input phase_type p);
      logic [PhaseWidth-1:0] c;
      unique case (p)
         PHASE_IDLE:  c = 2'd0;
         PHASE_TEMP:  c = 2'd1;
         PHASE_PRESS: c = 2'd2;
         PHASE_O2:    c = 2'd3;
         default:     c = 2'd0;
      endcase
      return c;
   endfunction

endpackage

>>> sv/timed_recipe_sequencer_core.sv
// Timed recipe sequencer: event decoder, settings store, phase timer and
// result register. Depends on trs_pkg.
//
// Usage:
//   req_* carries one event word per accepted cycle: opcode (tick, ADC sample,
//   save, mode toggle, start/select, next item) and the 12-bit ADC sample.
//   rsp_* returns exactly one status word per event, showing the state after
//   that event: mode, selected item, phase, elapsed ticks, plasma duty,
//   running flag and preview value.
//   Latency: the status word is valid the cycle after its event is accepted.
//   Throughput: one event per cycle while req_stall is low; all decode and update
//   logic sits between the state registers and the single result register.
//   req_stall rises only when a status word is held and rsp_stall is high;
//   while the receiver stalls, the held word does not change and no new
//   event is taken.
//   Reset (synchronous, active high) returns mode to input idle and phase to
//   idle, clears item, tick count, the latest sample and all stored times and
//   duty to zero, and empties the result register.
module timed_recipe_sequencer_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [trs_pkg::OpcodeWidth-1:0]   req_opcode,
   input  logic [trs_pkg::AdcWidth-1:0]      req_adc_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [trs_pkg::ModeWidth-1:0]     rsp_mode,
   output logic [trs_pkg::ItemWidth-1:0]     rsp_selected_item,
   output logic [trs_pkg::PhaseWidth-1:0]    rsp_phase,
   output logic [trs_pkg::TimeWidth-1:0]     rsp_elapsed_ticks,
   output logic [trs_pkg::DutyWidth-1:0]     rsp_duty_tenths,
   output logic                              rsp_running,
   output logic [trs_pkg::TimeWidth-1:0]     rsp_preview_value
);
   import trs_pkg::*;

   mode_type              mode_ff, mode_in;
   phase_type             phase_ff, phase_in;
   logic [ItemWidth-1:0]  item_ff, item_in;
   logic [QuantWidth-1:0] quant_ff, quant_in;
   logic [DutyWidth-1:0]  duty_ff, duty_in;
   logic [TimeWidth-1:0]  temp_time_ff, temp_time_in;
   logic [TimeWidth-1:0]  press_time_ff, press_time_in;
   logic [TimeWidth-1:0]  o2_time_ff, o2_time_in;
   logic [DutyWidth-1:0]  stored_duty_ff, stored_duty_in;
   logic [TimeWidth-1:0]  tick_ff, tick_in;

   logic                  rsp_valid_ff;
   logic [ModeWidth-1:0]  rsp_mode_ff;
   logic [ItemWidth-1:0]  rsp_item_ff;
   logic [PhaseWidth-1:0] rsp_phase_ff;
   logic [TimeWidth-1:0]  rsp_ticks_ff;
   logic [DutyWidth-1:0]  rsp_duty_ff;
   logic                  rsp_running_ff;
   logic [TimeWidth-1:0]  rsp_preview_ff;

   logic                  accept;
   logic [TimeWidth-1:0]  limit;
   logic [TimeWidth-1:0]  tick_inc;
   logic [TimeWidth-1:0]  save_value;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      unique case (phase_ff)
         PHASE_TEMP:  limit = temp_time_ff;
         PHASE_PRESS: limit = press_time_ff;
         default:     limit = o2_time_ff;
      endcase
   end

   assign tick_inc   = tick_ff + TimeWidth'(1);
   assign save_value = item_value(item_ff, quant_ff, duty_ff);

   always_comb begin
      mode_in        = mode_ff;
      phase_in       = phase_ff;
      item_in        = item_ff;
      quant_in       = quant_ff;
      duty_in        = duty_ff;
      temp_time_in   = temp_time_ff;
      press_time_in  = press_time_ff;
      o2_time_in     = o2_time_ff;
      stored_duty_in = stored_duty_ff;
      tick_in        = tick_ff;

      unique case (req_opcode)
         OP_TICK: begin
            if (phase_ff != PHASE_IDLE) begin
               if (tick_inc > limit) begin
                  tick_in = '0;
                  unique case (phase_ff)
                     PHASE_TEMP:  phase_in = PHASE_PRESS;
                     PHASE_PRESS: phase_in = PHASE_O2;
                     default:     phase_in = PHASE_IDLE;
                  endcase
               end else begin
                  tick_in = tick_inc;
               end
            end
         end
         OP_SAMPLE: begin
            quant_in = quantize(req_adc_sample);
            duty_in  = duty_of(req_adc_sample);
         end
         OP_SAVE: begin
            if (mode_ff == MODE_DETAIL) begin
               unique case (item_ff)
                  ITEM_TEMP:  temp_time_in   = save_value;
                  ITEM_PRESS: press_time_in  = save_value;
                  ITEM_O2:    o2_time_in     = save_value;
                  ITEM_DUTY:  stored_duty_in = DutyWidth'(save_value);
                  default:    ;
               endcase
            end
         end
         OP_TOGGLE: begin
            if (mode_ff == MODE_INPUT_IDLE)    mode_in = MODE_RUN_IDLE;
            else if (mode_ff == MODE_RUN_IDLE) mode_in = MODE_INPUT_IDLE;
         end
         OP_START: begin
            unique case (mode_ff)
               MODE_INPUT_IDLE: mode_in = MODE_DETAIL;
               MODE_RUN_IDLE: begin
                  // a start while an earlier run is still going is ignored
                  if (phase_ff == PHASE_IDLE) begin
                     mode_in  = MODE_RUN;
                     phase_in = PHASE_TEMP;
                     tick_in  = '0;
                  end
               end
               MODE_DETAIL: begin
                  mode_in = MODE_INPUT_IDLE;
                  item_in = ITEM_NONE;
               end
               default: mode_in = MODE_RUN_IDLE;
            endcase
         end
         OP_NEXT: begin
            if (mode_ff == MODE_DETAIL)
               item_in = (item_ff >= ITEM_DUTY) ? ITEM_TEMP : item_ff + ItemWidth'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_INPUT_IDLE;
         phase_ff       <= PHASE_IDLE;
         item_ff        <= ITEM_NONE;
         quant_ff       <= '0;
         duty_ff        <= '0;
         temp_time_ff   <= '0;
         press_time_ff  <= '0;
         o2_time_ff     <= '0;
         stored_duty_ff <= '0;
         tick_ff        <= '0;
      end else if (accept) begin
         mode_ff        <= mode_in;
         phase_ff       <= phase_in;
         item_ff        <= item_in;
         quant_ff       <= quant_in;
         duty_ff        <= duty_in;
         temp_time_ff   <= temp_time_in;
         press_time_ff  <= press_time_in;
         o2_time_ff     <= o2_time_in;
         stored_duty_ff <= stored_duty_in;
         tick_ff        <= tick_in;
      end
   end

   // result register: status word after the event
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_mode_ff    <= mode_code(mode_in);
         rsp_item_ff    <= item_in;
         rsp_phase_ff   <= phase_code(phase_in);
         rsp_ticks_ff   <= tick_in;
         rsp_duty_ff    <= (phase_in == PHASE_O2) ? stored_duty_in : '0;
         rsp_running_ff <= (phase_in != PHASE_IDLE);
         rsp_preview_ff <= item_value(item_in, quant_in, duty_in);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mode          = rsp_mode_ff;
   assign rsp_selected_item = rsp_item_ff;
   assign rsp_phase         = rsp_phase_ff;
   assign rsp_elapsed_ticks = rsp_ticks_ff;
   assign rsp_duty_tenths   = rsp_duty_ff;
   assign rsp_running       = rsp_running_ff;
   assign rsp_preview_value = rsp_preview_ff;

endmodule

>>> verif/testbench.sv
// Self-checking testbench for timed_recipe_sequencer_core: directed event table, then
// state-steered random events, checked word by word against an in-bench predictor.
// Depends on trs_pkg and timed_recipe_sequencer_core.
`timescale 1ns / 1ps

module testbench;

   localparam int CycleLimit = 200000;
   localparam int RandomWords = 1072;

   // opcodes the package leaves unnamed; the block must ignore them
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;

   // mode and phase as they appear on the result ports
   localparam logic [1:0] MD_INPUT    = 2'd0;
   localparam logic [1:0] MD_RUN_IDLE = 2'd1;
   localparam logic [1:0] MD_DETAIL   = 2'd2;
   localparam logic [1:0] MD_RUN      = 2'd3;
   localparam logic [1:0] PH_IDLE     = 2'd0;
   localparam logic [1:0] PH_TEMP     = 2'd1;
   localparam logic [1:0] PH_PRESS    = 2'd2;
   localparam logic [1:0] PH_O2       = 2'd3;

   typedef struct packed {
      logic [trs_pkg::ModeWidth-1:0]  mode;
      logic [trs_pkg::ItemWidth-1:0]  item;
      logic [trs_pkg::PhaseWidth-1:0] phase;
      logic [trs_pkg::TimeWidth-1:0]  ticks;
      logic [trs_pkg::DutyWidth-1:0]  duty;
      logic                           running;
      logic [trs_pkg::TimeWidth-1:0]  preview;
   } status_type;

   typedef struct {
      logic [trs_pkg::OpcodeWidth-1:0] op;
      logic [trs_pkg::AdcWidth-1:0]    adc;
      bit                              typed;
      status_type                      want;
   } plan_row_type;

   logic                              clock          = 1'b0;
   logic                              reset          = 1'b1;
   logic                              req_valid      = 1'b0;
   logic [trs_pkg::OpcodeWidth-1:0]   req_opcode     = '0;
   logic [trs_pkg::AdcWidth-1:0]      req_adc_sample = '0;
   logic                              rsp_stall      = 1'b0;
   logic                              req_stall;
   logic                              rsp_valid;
   logic [trs_pkg::ModeWidth-1:0]     rsp_mode;
   logic [trs_pkg::ItemWidth-1:0]     rsp_selected_item;
   logic [trs_pkg::PhaseWidth-1:0]    rsp_phase;
   logic [trs_pkg::TimeWidth-1:0]     rsp_elapsed_ticks;
   logic [trs_pkg::DutyWidth-1:0]     rsp_duty_tenths;
   logic                              rsp_running;
   logic [trs_pkg::TimeWidth-1:0]     rsp_preview_value;

   always #5 clock = ~clock;

   timed_recipe_sequencer_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_adc_sample    (req_adc_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_mode          (rsp_mode),
      .rsp_selected_item (rsp_selected_item),
      .rsp_phase         (rsp_phase),
      .rsp_elapsed_ticks (rsp_elapsed_ticks),
      .rsp_duty_tenths   (rsp_duty_tenths),
      .rsp_running       (rsp_running),
      .rsp_preview_value (rsp_preview_value)
   );

   // predicted sequencer state
   logic [1:0] mode_now;
   logic [2:0] item_now;
   logic [2:0] quant_now;
   logic [3:0] duty_now;
   logic [5:0] temp_set;
   logic [5:0] press_set;
   logic [5:0] o2_set;
   logic [3:0] duty_set;
   logic [1:0] phase_now;
   logic [5:0] ticks_now;

   status_type status_due[$];
   int errors        = 0;
   int words_sent    = 0;
   int words_checked = 0;
   int runs_done     = 0;
   int deepest_tick  = 0;
   int cycles        = 0;
   int tx_idle_pct   = 11;
   int rx_idle_pct   = 48;
   bit hold_done     = 1'b0;
   int hold_left     = 0;

   task automatic report_error(input string msg);
      errors++;
      $display("ERROR cycle %0d: %s", cycles, msg);
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want) report_error($sformatf("%s is %0d, expected %0d", name, got, want));
   endtask

   function automatic logic [5:0] preview_of(input logic [2:0] item);
      case (item)
         trs_pkg::ITEM_TEMP:  return 6'(trs_pkg::StepTenths * (int'(quant_now) + 2));
         trs_pkg::ITEM_PRESS: return 6'(trs_pkg::StepTenths * (int'(quant_now) + 1));
         trs_pkg::ITEM_O2:    return 6'(trs_pkg::StepTenths * int'(quant_now));
         trs_pkg::ITEM_DUTY:  return 6'(duty_now);
         default:             return 6'd0;
      endcase
   endfunction

   task automatic clear_recipe();
      mode_now  = MD_INPUT;
      item_now  = trs_pkg::ITEM_NONE;
      quant_now = '0;
      duty_now  = '0;
      temp_set  = '0;
      press_set = '0;
      o2_set    = '0;
      duty_set  = '0;
      phase_now = PH_IDLE;
      ticks_now = '0;
   endtask

   // applies one event word and returns the status word it should produce
   task automatic step_sequencer(input logic [2:0] op, input logic [11:0] adc,
                                 output status_type s);
      logic [5:0] limit;
      case (op)
         trs_pkg::OP_TICK: begin
            if (phase_now != PH_IDLE) begin
               limit = (phase_now == PH_TEMP) ? temp_set :
                       (phase_now == PH_PRESS) ? press_set : o2_set;
               ticks_now = ticks_now + 6'd1;
               if (int'(ticks_now) > deepest_tick) deepest_tick = int'(ticks_now);
               if (ticks_now > limit) begin
                  if (phase_now == PH_O2) begin
                     phase_now = PH_IDLE;
                     runs_done++;
                  end else begin
                     phase_now = phase_now + 2'd1;
                  end
                  ticks_now = '0;
               end
            end
         end
         trs_pkg::OP_SAMPLE: begin
            quant_now = 3'((32'(adc) * trs_pkg::QuantNum) / trs_pkg::QuantDen);
            duty_now  = 4'(32'(adc) / trs_pkg::DutyDen);
         end
         trs_pkg::OP_SAVE: begin
            if (mode_now == MD_DETAIL) begin
               case (item_now)
                  trs_pkg::ITEM_TEMP:  temp_set  = preview_of(item_now);
                  trs_pkg::ITEM_PRESS: press_set = preview_of(item_now);
                  trs_pkg::ITEM_O2:    o2_set    = preview_of(item_now);
                  trs_pkg::ITEM_DUTY:  duty_set  = 4'(preview_of(item_now));
                  default: ;
               endcase
            end
         end
         trs_pkg::OP_TOGGLE: begin
            if (mode_now == MD_INPUT) mode_now = MD_RUN_IDLE;
            else if (mode_now == MD_RUN_IDLE) mode_now = MD_INPUT;
         end
         trs_pkg::OP_START: begin
            case (mode_now)
               MD_INPUT: mode_now = MD_DETAIL;
               MD_RUN_IDLE: begin
                  // a start while an earlier run still counts is dropped
                  if (phase_now == PH_IDLE) begin
                     mode_now  = MD_RUN;
                     phase_now = PH_TEMP;
                     ticks_now = '0;
                  end
               end
               MD_DETAIL: begin
                  mode_now = MD_INPUT;
                  item_now = trs_pkg::ITEM_NONE;
               end
               default: mode_now = MD_RUN_IDLE;
            endcase
         end
         trs_pkg::OP_NEXT: begin
            if (mode_now == MD_DETAIL)
               item_now = (item_now >= trs_pkg::ITEM_DUTY) ? trs_pkg::ITEM_TEMP : item_now + 3'd1;
         end
         default: ;
      endcase
      s.mode    = mode_now;
      s.item    = item_now;
      s.phase   = phase_now;
      s.ticks   = ticks_now;
      s.duty    = (phase_now == PH_O2) ? duty_set : 4'd0;
      s.running = (phase_now != PH_IDLE);
      s.preview = preview_of(item_now);
   endtask

   function automatic status_type st(input logic [1:0] mode, input logic [2:0] item,
                                     input logic [5:0] preview);
      status_type s;
      s = '0;
      s.mode    = mode;
      s.item    = item;
      s.preview = preview;
      return s;
   endfunction

   function automatic plan_row_type ev(input logic [2:0] op, input logic [11:0] adc);
      plan_row_type r;
      r.op    = op;
      r.adc   = adc;
      r.typed = 1'b0;
      r.want  = '0;
      return r;
   endfunction

   function automatic plan_row_type ev_sure(input logic [2:0] op, input logic [11:0] adc,
                                            input status_type want);
      plan_row_type r;
      r       = ev(op, adc);
      r.typed = 1'b1;
      r.want  = want;
      return r;
   endfunction

   // steer by predicted mode so most words walk through programming and runs
   function automatic logic [2:0] pick_opcode();
      int roll;
      roll = $urandom_range(99);
      if (roll < 8) return 3'($urandom_range(7));
      case (mode_now)
         MD_INPUT: begin
            if (roll < 50) return trs_pkg::OP_START;
            if (roll < 80) return trs_pkg::OP_TOGGLE;
            if (roll < 90) return trs_pkg::OP_TICK;
            return trs_pkg::OP_SAMPLE;
         end
         MD_DETAIL: begin
            if (roll < 35) return trs_pkg::OP_SAMPLE;
            if (roll < 60) return trs_pkg::OP_NEXT;
            if (roll < 88) return trs_pkg::OP_SAVE;
            if (roll < 95) return trs_pkg::OP_START;
            return (roll < 97) ? trs_pkg::OP_TOGGLE : trs_pkg::OP_TICK;
         end
         MD_RUN_IDLE: begin
            if (phase_now != PH_IDLE) begin
               if (roll < 70) return trs_pkg::OP_TICK;
               return (roll < 85) ? trs_pkg::OP_START : trs_pkg::OP_TOGGLE;
            end
            if (roll < 60) return trs_pkg::OP_START;
            return (roll < 85) ? trs_pkg::OP_TOGGLE : trs_pkg::OP_TICK;
         end
         default: begin
            if (roll < 80) return trs_pkg::OP_TICK;
            if (roll < 88) return trs_pkg::OP_START;
            if (roll < 94) return trs_pkg::OP_SAMPLE;
            return (roll < 97) ? trs_pkg::OP_SAVE : trs_pkg::OP_NEXT;
         end
      endcase
   endfunction

   // small samples keep runs short; the rest hit full range and step edges
   function automatic logic [11:0] pick_adc();
      int roll;
      int k;
      roll = $urandom_range(99);
      k    = $urandom_range(1, trs_pkg::QuantMax);
      if (roll < 45) return 12'($urandom_range(1200));
      if (roll < 75) return 12'($urandom());
      if (roll < 85)
         return 12'((trs_pkg::QuantDen * k + trs_pkg::QuantNum - 1) / trs_pkg::QuantNum
                    - $urandom_range(1));
      if (roll < 95)
         return 12'(trs_pkg::DutyDen * $urandom_range(1, trs_pkg::DutyMax) - $urandom_range(1));
      return (roll < 97) ? 12'd0 : 12'hFFF;
   endfunction

   task automatic send_word(input plan_row_type r);
      status_type s;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= r.op;
      req_adc_sample <= r.adc;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      step_sequencer(r.op, r.adc, s);
      status_due.push_back(r.typed ? r.want : s);
      words_sent++;
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CycleLimit) begin
         $display("Timeout after %0d cycles, %0d words outstanding", cycles, status_due.size());
         $display("FAIL timed_recipe_sequencer_core");
         $finish;
      end
   end

   // receiver: random stalls plus one long hold-off so the block backs up
   always @(negedge clock) begin
      if (!hold_done && words_sent >= 250) begin
         hold_done = 1'b1;
         hold_left = 90;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      status_type got;
      status_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.mode    = rsp_mode;
         got.item    = rsp_selected_item;
         got.phase   = rsp_phase;
         got.ticks   = rsp_elapsed_ticks;
         got.duty    = rsp_duty_tenths;
         got.running = rsp_running;
         got.preview = rsp_preview_value;
         if (status_due.size() == 0) begin
            report_error("status word with nothing expected");
         end else begin
            want = status_due.pop_front();
            words_checked++;
            check_field("mode", 8'(got.mode), 8'(want.mode));
            check_field("selected_item", 8'(got.item), 8'(want.item));
            check_field("phase", 8'(got.phase), 8'(want.phase));
            check_field("elapsed_ticks", 8'(got.ticks), 8'(want.ticks));
            check_field("duty_tenths", 8'(got.duty), 8'(want.duty));
            check_field("running", 8'(got.running), 8'(want.running));
            check_field("preview_value", 8'(got.preview), 8'(want.preview));
         end
      end
   end

   initial begin
      plan_row_type plan[$];
      plan_row_type r;
      int i;
      clear_recipe();

      // after reset: spare opcodes, idle tick, sample, save and next all leave zeros
      plan.push_back(ev_sure(OP_SPARE_A, 12'hFFF, st(MD_INPUT, trs_pkg::ITEM_NONE, 0)));
      plan.push_back(ev_sure(OP_SPARE_B, 12'h000, st(MD_INPUT, trs_pkg::ITEM_NONE, 0)));
      plan.push_back(ev_sure(trs_pkg::OP_TICK, 12'hABC, st(MD_INPUT, trs_pkg::ITEM_NONE, 0)));
      plan.push_back(ev_sure(trs_pkg::OP_SAMPLE, 12'hFFF, st(MD_INPUT, trs_pkg::ITEM_NONE, 0)));
      plan.push_back(ev_sure(trs_pkg::OP_SAVE, 12'h555, st(MD_INPUT, trs_pkg::ITEM_NONE, 0)));
      plan.push_back(ev_sure(trs_pkg::OP_NEXT, 12'h000, st(MD_INPUT, trs_pkg::ITEM_NONE, 0)));
      plan.push_back(ev_sure(trs_pkg::OP_START, 12'h000, st(MD_DETAIL, trs_pkg::ITEM_NONE, 0)));
      // save with no item selected
      plan.push_back(ev_sure(trs_pkg::OP_SAVE, 12'h000, st(MD_DETAIL, trs_pkg::ITEM_NONE, 0)));
      // full-scale sample: longest times and top duty stored for every item
      plan.push_back(ev_sure(trs_pkg::OP_NEXT, 12'h000, st(MD_DETAIL, trs_pkg::ITEM_TEMP, 40)));
      plan.push_back(ev(trs_pkg::OP_SAVE, 12'h000));
      plan.push_back(ev(trs_pkg::OP_NEXT, 12'h000));
      plan.push_back(ev(trs_pkg::OP_SAVE, 12'h000));
      plan.push_back(ev(trs_pkg::OP_NEXT, 12'h000));
      plan.push_back(ev(trs_pkg::OP_SAVE, 12'h000));
      plan.push_back(ev_sure(trs_pkg::OP_NEXT, 12'h000, st(MD_DETAIL, trs_pkg::ITEM_DUTY, 9)));
      plan.push_back(ev(trs_pkg::OP_SAVE, 12'h000));
      plan.push_back(ev_sure(trs_pkg::OP_NEXT, 12'h000, st(MD_DETAIL, trs_pkg::ITEM_TEMP, 40)));
      plan.push_back(ev_sure(trs_pkg::OP_SAMPLE, 12'h000, st(MD_DETAIL, trs_pkg::ITEM_TEMP, 10)));
      // either side of the first quantizer step
      plan.push_back(ev(trs_pkg::OP_SAMPLE, 12'd585));
      plan.push_back(ev(trs_pkg::OP_SAMPLE, 12'd586));
      plan.push_back(ev(trs_pkg::OP_SAVE, 12'h000));
      plan.push_back(ev(trs_pkg::OP_TOGGLE, 12'h000));
      plan.push_back(ev_sure(trs_pkg::OP_START, 12'h000, st(MD_INPUT, trs_pkg::ITEM_NONE, 0)));
      plan.push_back(ev_sure(trs_pkg::OP_TOGGLE, 12'h000, st(MD_RUN_IDLE, trs_pkg::ITEM_NONE, 0)));
      plan.push_back(ev(trs_pkg::OP_START, 12'h000));
      plan.push_back(ev(trs_pkg::OP_TICK, 12'h000));
      // leave run mode mid-run, then a start that must be dropped
      plan.push_back(ev(trs_pkg::OP_START, 12'h000));
      plan.push_back(ev(trs_pkg::OP_START, 12'h000));

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) send_word(plan[i]);

      for (i = 0; i < RandomWords; i++) begin
         if (i == RandomWords / 3) begin
            tx_idle_pct = 48;
            rx_idle_pct = 11;
         end
         if (i == 2 * RandomWords / 3) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         r = ev(pick_opcode(), pick_adc());
         send_word(r);
      end
      req_valid <= 1'b0;

      while (status_due.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Sent %0d event words, checked %0d status words, %0d mismatches.",
               words_sent, words_checked, errors);
      $display("Completed %0d recipe runs; longest phase count reached %0d ticks.",
               runs_done, deepest_tick);
      if (errors == 0 && status_due.size() == 0) begin
         $display("PASS timed_recipe_sequencer_core");
      end else begin
         $display("FAIL timed_recipe_sequencer_core");
      end
      $finish;
   end

endmodule
